@@ rtl/mat4_vec4_transform_defines.svh @@
// ----------------------------------------------------------------------------
// mat4_vec4_transform_defines
// Assertion macros shared by the matrix-vector transform RTL.
// ----------------------------------------------------------------------------
`ifndef MAT4_VEC4_TRANSFORM_DEFINES_SVH
`define MAT4_VEC4_TRANSFORM_DEFINES_SVH

// Check a consequence in the same cycle as its trigger.
`define M4V4_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mat4_vec4_transform: same-cycle check failed");

// Check a consequence in the cycle after its trigger.
`define M4V4_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mat4_vec4_transform: next-cycle check failed");

`endif

@@ rtl/m4v4_pkg.sv @@
// ----------------------------------------------------------------------------
// m4v4_pkg
// Types and constants for the 4x4 matrix times 4-vector transform.
// ----------------------------------------------------------------------------
`default_nettype none

package m4v4_pkg;

    // Q16.16 word and fraction width
    localparam int Q_W       = 32;
    localparam int FRAC_BITS = 16;

    // Matrix register file geometry
    localparam int NUM_MAT_REGS = 8;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 64;

    // Product and accumulation widths
    localparam int PROD_W = 2 * Q_W;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAT_R0_C01 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAT_R0_C23 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAT_R1_C01 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAT_R1_C23 = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAT_R2_C01 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAT_R2_C23 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAT_R3_C01 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAT_R3_C23 = 4'd7;

    // Identity matrix after reset
    localparam logic [CFG_DATA_W-1:0] MAT_RESET [NUM_MAT_REGS] = '{
        64'h0000_0000_0001_0000, 64'h0,
        64'h0001_0000_0000_0000, 64'h0,
        64'h0,                   64'h0000_0000_0001_0000,
        64'h0,                   64'h0001_0000_0000_0000
    };

    // Saturation limits
    localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

    typedef logic signed [Q_W-1:0] q_t;
    typedef logic [3:0][Q_W-1:0]   q_quad_t;

    typedef struct packed {
        logic signed [Q_W-1:0] vec_x;
        logic signed [Q_W-1:0] vec_y;
        logic signed [Q_W-1:0] vec_z;
        logic signed [Q_W-1:0] vec_w;
    } vec_item_t;

    typedef struct packed {
        logic signed [Q_W-1:0] out_x;
        logic signed [Q_W-1:0] out_y;
        logic signed [Q_W-1:0] out_z;
        logic signed [Q_W-1:0] out_w;
    } res_item_t;

endpackage

`default_nettype wire

@@ rtl/m4v4_row_dot.sv @@
// ----------------------------------------------------------------------------
// m4v4_row_dot
// One matrix row dotted with the vector: multiply, pair add, final add with
// shift and saturation, each in its own register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module m4v4_row_dot
    import m4v4_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           en,
    input  wire q_quad_t        vec,
    input  wire q_quad_t        row,
    output      logic [Q_W-1:0] result
);

    logic signed [PROD_W-1:0] prod_reg [4];
    logic signed [PAIR_W-1:0] pair_reg [2];
    logic        [Q_W-1:0]    result_reg;

    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  shifted;
    logic        [Q_W-1:0]    result_next;

    // Stage A: four 32x32 signed products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 4; j++)
            begin
                prod_reg[j] <= $signed(vec[j]) * $signed(row[j]);
            end
        end
    end

    // Stage B: add products in pairs
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pair_reg[0] <= {prod_reg[0][PROD_W-1], prod_reg[0]}
                         + {prod_reg[1][PROD_W-1], prod_reg[1]};
            pair_reg[1] <= {prod_reg[2][PROD_W-1], prod_reg[2]}
                         + {prod_reg[3][PROD_W-1], prod_reg[3]};
        end
    end

    // Stage C: final sum, floor shift, saturate
    always_comb
    begin
        sum_next = {pair_reg[0][PAIR_W-1], pair_reg[0]}
                 + {pair_reg[1][PAIR_W-1], pair_reg[1]};
        shifted  = sum_next >>> FRAC_BITS;
        if ((&shifted[SUM_W-1:Q_W-1]) || !(|shifted[SUM_W-1:Q_W-1]))
        begin
            result_next = shifted[Q_W-1:0];
        end
        else if (shifted[SUM_W-1])
        begin
            result_next = Q_MIN;
        end
        else
        begin
            result_next = Q_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

@@ rtl/mat4_vec4_transform.sv @@
// Throughput: one item per cycle; a stalled output holds every stage, and in_stall
// follows out_stall while the output register is full.
// Path: input register, 32x32 multipliers, pair adders, final add with saturation.
// Reset clears all valid bits and loads the identity matrix into the registers.
// ----------------------------------------------------------------------------
// mat4_vec4_transform
// Pipelined Q16.16 transform of a 4-vector by a configurable 4x4 matrix.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mat4_vec4_transform_defines.svh"

module mat4_vec4_transform
    import m4v4_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Input channel
    input  wire logic                  in_valid,
    output      logic                  in_stall,
    input  wire vec_item_t             in_item,
    // Output channel
    output      logic                  out_valid,
    input  wire logic                  out_stall,
    output      res_item_t             out_item
);

    logic [CFG_DATA_W-1:0] mat_reg [NUM_MAT_REGS];
    vec_item_t             vec_reg;
    logic                  v1_reg;
    logic                  v2_reg;
    logic                  v3_reg;
    logic                  out_valid_reg;
    logic                  adv;
    q_quad_t               vec_lanes;
    q_quad_t               row_ent [4];
    logic [Q_W-1:0]        row_res [4];

    // Advance the whole pipe unless a finished item waits at the output
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // Matrix registers: write by index, ignore indexes past the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_MAT_REGS; i++)
            begin
                mat_reg[i] <= MAT_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAT_R0_C01: mat_reg[0] <= cfg_data;
                REG_MAT_R0_C23: mat_reg[1] <= cfg_data;
                REG_MAT_R1_C01: mat_reg[2] <= cfg_data;
                REG_MAT_R1_C23: mat_reg[3] <= cfg_data;
                REG_MAT_R2_C01: mat_reg[4] <= cfg_data;
                REG_MAT_R2_C23: mat_reg[5] <= cfg_data;
                REG_MAT_R3_C01: mat_reg[6] <= cfg_data;
                REG_MAT_R3_C23: mat_reg[7] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Move valid bits along with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    // Capture the accepted vector
    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            vec_reg <= in_item;
        end
    end

    assign vec_lanes[0] = vec_reg.vec_x;
    assign vec_lanes[1] = vec_reg.vec_y;
    assign vec_lanes[2] = vec_reg.vec_z;
    assign vec_lanes[3] = vec_reg.vec_w;

    // Unpack matrix rows: entry 2k low half, entry 2k+1 high half
    for (genvar r = 0; r < 4; r++)
    begin : g_row
        assign row_ent[r][0] = mat_reg[2*r][Q_W-1:0];
        assign row_ent[r][1] = mat_reg[2*r][CFG_DATA_W-1:Q_W];
        assign row_ent[r][2] = mat_reg[2*r+1][Q_W-1:0];
        assign row_ent[r][3] = mat_reg[2*r+1][CFG_DATA_W-1:Q_W];

        m4v4_row_dot u_row_dot (
            .clk    (clk),
            .en     (adv),
            .vec    (vec_lanes),
            .row    (row_ent[r]),
            .result (row_res[r])
        );
    end

    assign out_valid      = out_valid_reg;
    assign out_item.out_x = row_res[0];
    assign out_item.out_y = row_res[1];
    assign out_item.out_z = row_res[2];
    assign out_item.out_w = row_res[3];

    // Pipeline checks
    `M4V4_ASSERT_NEXT(a_stall_freezes, out_valid_reg && out_stall,
        $stable(v1_reg) && $stable(v2_reg) && $stable(v3_reg) && out_valid_reg)
    `M4V4_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, v1_reg)
    `M4V4_ASSERT_NEXT(a_last_stage_moves, v3_reg && adv, out_valid_reg)
    `M4V4_ASSERT_NEXT(a_bubble_moves, !v2_reg && adv, !v3_reg)

endmodule

`default_nettype wire
